@@ src/rotated_fill_long_codec_top_defines.svh @@
// ----------------------------------------------------------------------------
// rotated fill long codec assertion macros
// shared property wrappers for the checker, clocked on clock, off in reset
// ----------------------------------------------------------------------------
`ifndef ROTATED_FILL_LONG_CODEC_TOP_DEFINES_SVH
`define ROTATED_FILL_LONG_CODEC_TOP_DEFINES_SVH

// same-cycle implication
`define RFLC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rflc assertion failed");

// next-cycle implication
`define RFLC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rflc assertion failed");

`endif

@@ src/rflc_pkg.sv @@
// ----------------------------------------------------------------------------
// rflc_pkg
// constants, types and helpers for the rotated fill long codec
// ----------------------------------------------------------------------------
package rflc_pkg;

   localparam int WORD_W    = 64;
   localparam int PAYLOAD_W = 48;
   localparam int ROT_W     = 6;
   localparam int FIDX_W    = 2;

   // operation codes
   localparam logic OP_ENCODE = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   // fill patterns and their indexes
   localparam logic [15:0] FILL_ZERO = 16'h0000;
   localparam logic [15:0] FILL_ALT  = 16'h5555;
   localparam logic [15:0] FILL_LOW  = 16'h00FF;
   localparam logic [15:0] FILL_ONES = 16'hFFFF;

   localparam logic [FIDX_W-1:0] FIDX_ZERO = 2'd0;
   localparam logic [FIDX_W-1:0] FIDX_ALT  = 2'd1;
   localparam logic [FIDX_W-1:0] FIDX_LOW  = 2'd2;
   localparam logic [FIDX_W-1:0] FIDX_ONES = 2'd3;

   typedef struct packed {
      logic              hit;
      logic [FIDX_W-1:0] idx;
   } fill_hit_type;

   // classify the top 16 bits of a word against all four fills
   function automatic fill_hit_type fill_lookup(input logic [15:0] top);
      fill_hit_type fh;
      fh.hit = 1'b1;
      fh.idx = FIDX_ZERO;
      unique case (top)
         FILL_ZERO: fh.idx = FIDX_ZERO;
         FILL_ALT:  fh.idx = FIDX_ALT;
         FILL_LOW:  fh.idx = FIDX_LOW;
         FILL_ONES: fh.idx = FIDX_ONES;
         default:   fh.hit = 1'b0;
      endcase
      return fh;
   endfunction

   // fill pattern for an index
   function automatic logic [15:0] fill_pattern(input logic [FIDX_W-1:0] idx);
      logic [15:0] pat;
      unique case (idx)
         FIDX_ZERO: pat = FILL_ZERO;
         FIDX_ALT:  pat = FILL_ALT;
         FIDX_LOW:  pat = FILL_LOW;
         default:   pat = FILL_ONES;
      endcase
      return pat;
   endfunction

   // index of the lowest set bit, zero when none
   function automatic logic [ROT_W-1:0] first_set(input logic [WORD_W-1:0] vec);
      logic [WORD_W-1:0] iso;
      logic [ROT_W-1:0]  idx;
      iso = vec & (~vec + 64'd1);
      idx = '0;
      for (int i = 0; i < WORD_W; i++) begin
         if (iso[i]) begin
            idx = idx | ROT_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

@@ src/rotated_fill_long_codec_top.sv @@
// ----------------------------------------------------------------------------
// rotated_fill_long_codec_top
// packs a 64-bit integer into a tagged word with a rotated fill, and unpacks
// ----------------------------------------------------------------------------
// usage
//   req channel: req_valid/req_stall with req_opcode (0 encode, 1 decode) and
//   req_value. a transfer happens on a clock edge with valid high, stall low.
//   rsp channel: rsp_valid/rsp_stall with rsp_result and rsp_ok, one transfer
//   per request, in request order.
//   path: a request goes into the input register, then into the result
//   register, where rsp_valid rises; the whole encode search or decode is
//   one pass of logic between them.
//   throughput: one transfer per cycle while the receiver keeps stall low.
//   the input register accepts a new word while a result still waits in the
//   result register; req_stall rises only when both registers are full and
//   rsp_stall is high. results hold steady while stalled.
//   reset (synchronous, active high) empties both registers; no state else.
// ----------------------------------------------------------------------------
module rotated_fill_long_codec_top
   import rflc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_opcode,
   input  logic [WORD_W-1:0] req_value,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [WORD_W-1:0] rsp_result,
   output logic              rsp_ok
);

   // input register
   logic              in_valid_ff, in_valid_in;
   logic              in_opcode_ff;
   logic [WORD_W-1:0] in_value_ff;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic [WORD_W-1:0] out_result_ff, out_result_in;
   logic              out_ok_ff, out_ok_in;

   logic advance;   // input register moves into the result register
   logic req_take;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   // encode search: match flags for every right rotation
   logic [2*WORD_W-1:0] enc_dbl;
   logic [WORD_W-1:0]   hit_all;   // top matches any fill
   logic [WORD_W-1:0]   hit_lim;   // top matches zero or ones only
   logic [3:0]          pass1_vec; // rotations by 16
   logic [7:0]          pass2_vec; // rotations by 8

   always_comb begin
      logic [15:0]  top;
      fill_hit_type fh;
      enc_dbl = {in_value_ff, in_value_ff};
      for (int r = 0; r < WORD_W; r++) begin
         top        = enc_dbl[r+PAYLOAD_W +: 16];
         fh         = fill_lookup(top);
         hit_all[r] = fh.hit;
         hit_lim[r] = (top == FILL_ZERO) || (top == FILL_ONES);
      end
      for (int i = 0; i < 4; i++) begin
         pass1_vec[i] = hit_lim[16*i];
      end
      for (int i = 0; i < 8; i++) begin
         pass2_vec[i] = hit_all[8*i];
      end
   end

   // pass priority: coarse zero/ones, then byte steps, then bit steps
   logic [ROT_W-1:0] idx1, idx2, idx3;
   logic [ROT_W-1:0] enc_rot;
   logic             enc_ok;

   assign idx1 = first_set({60'd0, pass1_vec});
   assign idx2 = first_set({56'd0, pass2_vec});
   assign idx3 = first_set(hit_all);

   always_comb begin
      enc_ok = 1'b1;
      priority if (|pass1_vec) begin
         enc_rot = {idx1[1:0], 4'b0000};
      end else if (|pass2_vec) begin
         enc_rot = {idx2[2:0], 3'b000};
      end else if (|hit_all) begin
         enc_rot = idx3;
      end else begin
         enc_rot = '0;
         enc_ok  = 1'b0;
      end
   end

   // rotate right by the chosen amount and pack
   logic [2*WORD_W-1:0] enc_shift;
   logic [WORD_W-1:0]   enc_rotated;
   fill_hit_type        enc_fill;
   logic [WORD_W-1:0]   enc_word;

   assign enc_shift   = enc_dbl >> enc_rot;
   assign enc_rotated = enc_shift[WORD_W-1:0];
   assign enc_fill    = fill_lookup(enc_rotated[WORD_W-1:PAYLOAD_W]);
   assign enc_word    = enc_ok ?
                        {3'b000, 1'b1, 4'b0000, enc_fill.idx, enc_rot,
                         enc_rotated[PAYLOAD_W-1:0]} :
                        '0;

   // decode: restore the fill, rotate left
   logic [ROT_W-1:0]    dec_rot;
   logic [FIDX_W-1:0]   dec_fidx;
   logic [WORD_W-1:0]   dec_raw;
   logic [2*WORD_W-1:0] dec_shift;

   assign dec_rot   = in_value_ff[PAYLOAD_W +: ROT_W];
   assign dec_fidx  = in_value_ff[PAYLOAD_W+ROT_W +: FIDX_W];
   assign dec_raw   = {fill_pattern(dec_fidx), in_value_ff[PAYLOAD_W-1:0]};
   assign dec_shift = {dec_raw, dec_raw} << dec_rot;

   always_comb begin
      unique case (in_opcode_ff)
         OP_ENCODE: begin
            out_result_in = enc_word;
            out_ok_in     = enc_ok;
         end
         default: begin
            out_result_in = dec_shift[2*WORD_W-1:WORD_W];
            out_ok_in     = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_opcode_ff <= req_opcode;
         in_value_ff  <= req_value;
      end
      if (advance) begin
         out_result_ff <= out_result_in;
         out_ok_ff     <= out_ok_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_result = out_result_ff;
   assign rsp_ok     = out_ok_ff;

endmodule

@@ src/rflc_checker.sv @@
// ----------------------------------------------------------------------------
// rflc_checker
// port-level checks for the rotated fill long codec, bound to the top level
// ----------------------------------------------------------------------------
`include "rotated_fill_long_codec_top_defines.svh"

module rflc_checker
   import rflc_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [WORD_W-1:0] rsp_result,
   input logic              rsp_ok
);

   // stalled result holds
   `RFLC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
                     rsp_valid && $stable(rsp_result) && $stable(rsp_ok))

   // failed encode gives an all-zero word
   `RFLC_ASSERT_NOW(a_fail_zero, rsp_valid && !rsp_ok, rsp_result == '0)

   // an open result side never backs up the request side
   `RFLC_ASSERT_NOW(a_no_false_stall, !rsp_stall, !req_stall)

   // nothing comes out right after reset
   `RFLC_ASSERT_NOW(a_reset_empty, $past(reset), !rsp_valid)

   // a request transfer always shows a valid result after the input register stage
   `RFLC_ASSERT_NEXT(a_fill_latency, $past(req_valid && !req_stall), rsp_valid)

endmodule

bind rotated_fill_long_codec_top rflc_checker u_rflc_checker (.*);

@@ tb/testbench.sv @@
// ----------------------------------------------------------------------------
// rotated fill long codec testbench
// drives encode and decode transfers through rotated_fill_long_codec_top and
// checks every result against a cycle-free model of the rotation search and
// the fill restore, with random idling on both sides and a long result hold
// ----------------------------------------------------------------------------
module testbench;
   import rflc_pkg::*;

   localparam int HALF_PERIOD   = 5;
   localparam int RESET_CYCLES  = 8;
   localparam int HOLD_CYCLES   = 60;
   localparam int BURST_ITEMS   = 40;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 200000;

   // field positions inside the tagged word
   localparam int ROT_LSB  = PAYLOAD_W;
   localparam int FIDX_LSB = PAYLOAD_W + ROT_W;

   // every block input starts at a known value
   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_valid  = 1'b0;
   logic              req_opcode = OP_ENCODE;
   logic [WORD_W-1:0] req_value  = '0;
   logic              rsp_stall  = 1'b0;
   logic              req_stall;
   logic              rsp_valid;
   logic [WORD_W-1:0] rsp_result;
   logic              rsp_ok;

   int send_idle_pct = 35;
   int recv_idle_pct = 72;
   int cycle_count   = 0;
   int hold_left     = 0;
   bit hold_go       = 1'b0;

   typedef struct {
      logic [WORD_W-1:0] word;
      logic              ok;
   } codec_result_type;

   // shifts by the full width give zero, so rotation zero needs no special case
   function automatic logic [WORD_W-1:0] rot_right(input logic [WORD_W-1:0] v, input int r);
      return (v >> r) | (v << (WORD_W - r));
   endfunction

   function automatic logic [WORD_W-1:0] rot_left(input logic [WORD_W-1:0] v, input int r);
      return (v << r) | (v >> (WORD_W - r));
   endfunction

   function automatic logic [15:0] fill_of(input logic [FIDX_W-1:0] idx);
      case (idx)
         FIDX_ZERO: return FILL_ZERO;
         FIDX_ALT:  return FILL_ALT;
         FIDX_LOW:  return FILL_LOW;
         default:   return FILL_ONES;
      endcase
   endfunction

   class codec_scoreboard;
      codec_result_type pending_results[$];
      int               mismatches;

      function new();
         mismatches = 0;
      endfunction

      // the coarse first pass only knows the all-zero and all-one fills
      function bit match_fill(input logic [15:0] top, input bit any_fill,
                              output logic [FIDX_W-1:0] idx);
         idx = FIDX_ZERO;
         if (top == FILL_ZERO) idx = FIDX_ZERO;
         else if (top == FILL_ONES) idx = FIDX_ONES;
         else if (any_fill && top == FILL_ALT) idx = FIDX_ALT;
         else if (any_fill && top == FILL_LOW) idx = FIDX_LOW;
         else return 1'b0;
         return 1'b1;
      endfunction

      function codec_result_type predict_codec(input logic op,
                                               input logic [WORD_W-1:0] val);
         codec_result_type  res;
         int                steps[3];
         logic [WORD_W-1:0] turned;
         logic [FIDX_W-1:0] idx;
         bit                found;
         steps = '{16, 8, 1};
         res.word = '0;
         res.ok = 1'b0;
         found = 1'b0;
         if (op == OP_DECODE) begin
            // bits 56-63 play no part in a decode
            turned = {fill_of(val[FIDX_LSB +: FIDX_W]), val[PAYLOAD_W-1:0]};
            res.word = rot_left(turned, int'(val[ROT_LSB +: ROT_W]));
            res.ok = 1'b1;
         end else begin
            for (int p = 0; p < 3 && !found; p++) begin
               for (int r = 0; r < WORD_W && !found; r += steps[p]) begin
                  turned = rot_right(val, r);
                  if (match_fill(turned[WORD_W-1 -: 16], p != 0, idx)) begin
                     found = 1'b1;
                     // tag at bit 60, the rest of the top byte clear
                     res.word = {3'b000, 1'b1, 4'b0000, idx, ROT_W'(r),
                                 turned[PAYLOAD_W-1:0]};
                     res.ok = 1'b1;
                  end
               end
            end
         end
         return res;
      endfunction

      function void note_request(input logic op, input logic [WORD_W-1:0] val);
         pending_results.push_back(predict_codec(op, val));
      endfunction

      function void flag(input string what, input logic [WORD_W-1:0] want,
                         input logic [WORD_W-1:0] got);
         mismatches++;
         $display("%0t: %s expected %h actual %h", $time, what, want, got);
      endfunction

      function void check_response(input logic [WORD_W-1:0] word, input logic ok);
         codec_result_type want;
         if (pending_results.size() == 0) begin
            flag("unexpected result, nothing", '0, word);
            return;
         end
         want = pending_results.pop_front();
         if (word !== want.word) flag("result", want.word, word);
         if (ok !== want.ok) flag("ok", WORD_W'(want.ok), WORD_W'(ok));
      endfunction
   endclass

   codec_scoreboard sb;

   rotated_fill_long_codec_top i_dut (.*);

   always #HALF_PERIOD clock = ~clock;

   // watchdog, counts every cycle of the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // result side: check each transfer, then pick the next stall value;
   // a requested long hold is counted down here
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_response(rsp_result, rsp_ok);
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_go) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         hold_go   <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
   end

   // one request transfer; the payload holds still while stalled and the
   // expectation is noted only once the transfer has happened
   task automatic send_item(input logic op, input logic [WORD_W-1:0] val);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_value  <= val;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(op, val);
   endtask

   // sender goes quiet until every outstanding result is back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   // half are encodable values built from a fill and a rotation, favoring the
   // coarse grids so each search pass wins often; some near misses, raw
   // values that rarely match, and raw decode words with junk in the top byte
   task automatic send_random(input int count);
      int                pick;
      logic [WORD_W-1:0] base;
      logic [WORD_W-1:0] val;
      logic              op;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         base = {$urandom, $urandom};
         op = OP_ENCODE;
         val = base;
         if (pick < 50) begin
            base[WORD_W-1 -: 16] = fill_of(FIDX_W'($urandom_range(0, 3)));
            case ($urandom_range(0, 2))
               0:       val = rot_left(base, 16 * $urandom_range(0, 3));
               1:       val = rot_left(base, 8 * $urandom_range(0, 7));
               default: val = rot_left(base, $urandom_range(0, 63));
            endcase
            // near miss: one flipped bit
            if (pick < 8) val[ROT_W'($urandom_range(0, 63))] ^= 1'b1;
         end else if (pick >= 70) begin
            op = OP_DECODE;
         end
         send_item(op, val);
      end
   endtask

   initial begin : stimulus
      sb = new();
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed encodes: extremes, a hit in each pass, priority, no match
      send_item(OP_ENCODE, 64'h0000_0000_0000_0000);
      send_item(OP_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(OP_ENCODE, 64'h0000_1234_5678_9ABC);
      send_item(OP_ENCODE, 64'hFFFF_8765_4321_0FED);
      send_item(OP_ENCODE, 64'h1234_5678_9ABC_FFFF);
      send_item(OP_ENCODE, 64'h5555_1234_5678_9ABC);
      send_item(OP_ENCODE, 64'h00FF_1234_5678_9ABC);
      send_item(OP_ENCODE, 64'h5534_5678_9ABC_DE55);
      send_item(OP_ENCODE, 64'hFFF8_91A2_B3C4_D5E7);
      send_item(OP_ENCODE, 64'hAAAA_AAAA_AAAA_AAAA);
      send_item(OP_ENCODE, 64'h0123_4567_89AB_CDEF);
      send_item(OP_ENCODE, 64'h8000_0000_0000_0001);
      // directed decodes: every fill, rotation zero and maximum, junk top byte
      send_item(OP_DECODE, {8'h10, FIDX_ZERO, 6'd0, 48'h1234_5678_9ABC});
      send_item(OP_DECODE, {8'h00, FIDX_ALT, 6'd0, 48'hFFFF_FFFF_FFFF});
      send_item(OP_DECODE, {8'h10, FIDX_LOW, 6'd8, 48'h8000_0000_0001});
      send_item(OP_DECODE, {8'hEF, FIDX_ONES, 6'd63, 48'h0000_0000_0000});
      send_item(OP_DECODE, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(OP_DECODE, 64'h0000_0000_0000_0000);
      send_random(260);

      // swap the idling sides
      wait_for_results();
      send_idle_pct = 72;
      recv_idle_pct <= 35;
      send_random(280);

      // no idling; the long hold lets both registers fill and stall requests
      wait_for_results();
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      hold_go <= 1'b1;
      send_random(BURST_ITEMS);
      send_random(250);

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_results.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

@@ files.f @@
+incdir+src
src/rflc_pkg.sv
src/rotated_fill_long_codec_top.sv
src/rflc_checker.sv
tb/testbench.sv
